[sv/sbmm_pkg.sv]
// sbmm_pkg: types, constants and register map of the strided batched matmul element core.
// No dependencies.
`default_nettype none
package sbmm_pkg;
  localparam int unsigned MemDepthDef  = 4096;
  localparam int unsigned MaxDimsDef   = 4;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned CfgAw        = 6;

  localparam logic [1:0] OpWrLeft  = 2'd0;
  localparam logic [1:0] OpWrRight = 2'd1;
  localparam logic [1:0] OpCompute = 2'd2;
  localparam logic [1:0] OpIgnore  = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadIndex = 2'd1;
  localparam logic [1:0] StBadAddr  = 2'd2;

  localparam logic [2:0] RegNumDims   = 3'd0;
  localparam logic [2:0] RegShape     = 3'd1;
  localparam logic [2:0] RegLStrides  = 3'd2;
  localparam logic [2:0] RegRStrides  = 3'd3;
  localparam logic [2:0] RegLBase     = 3'd4;
  localparam logic [2:0] RegRBase     = 3'd5;
  localparam logic [2:0] RegInnerLen  = 3'd6;
  localparam logic [2:0] RegResCount  = 3'd7;

  typedef struct packed {
    logic [1:0]         op;
    logic [11:0]        mem_address;
    logic signed [31:0] write_value;
    logic [23:0]        result_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] product_value;
    logic [23:0]        echo_index;
    logic [1:0]         status;
  } out_item_t;
endpackage
`default_nettype wire

[sv/sbmm_ram.sv]
// sbmm_ram: generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module sbmm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

[sv/strided_batched_matmul_element_core.sv]
// Strided batched matmul element core: top level with APB registers, sequencer and MAC.
// Depends on sbmm_pkg and sbmm_ram.
//
//  channel | signals                                   | transfer
//  in      | start_i, busy_o, in_item_i                | start_i && !busy_o
//  out     | result_valid_o, out_item_o                | result_valid_o (one cycle)
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata   | psel&&penable&&pwrite
//
// Write items leave busy_o low. A compute item holds busy_o through an index check,
// a bit-serial index divide and one offset step per dimension, an address check,
// one read per product, the MAC pipeline drain and the output.
// Index out of range skips to output; address out of range or zero inner skips the reads.
// Async reset clears control and registers; memories are undefined until written.
// The receiver cannot stall; the result shows in the cycle busy_o falls.
`default_nettype none
module strided_batched_matmul_element_core #(
  parameter int unsigned MEM_DEPTH  = sbmm_pkg::MemDepthDef,
  parameter int unsigned MAX_DIMS   = sbmm_pkg::MaxDimsDef,
  parameter int unsigned DATA_WIDTH = sbmm_pkg::DataWidthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sbmm_pkg::CfgAw-1:0]   paddr,
  input  wire logic [63:0]                  pwdata,
  output logic      [63:0]                  prdata,
  output logic                              pready,
  input  wire logic                         start_i,
  input  wire sbmm_pkg::in_item_t           in_item_i,
  output logic                              busy_o,
  output logic                              result_valid_o,
  output sbmm_pkg::out_item_t               out_item_o
);
  localparam int unsigned Aw = $clog2(MEM_DEPTH);
  localparam int unsigned DimW = $clog2(MAX_DIMS);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StDiv   = 7'b0000010,
    StAcc   = 7'b0000100,
    StCheck = 7'b0001000,
    StRead  = 7'b0010000,
    StMac   = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  logic [2:0]  nd_q;
  logic [63:0] shape_q, lstr_q, rstr_q;
  logic [11:0] lbase_q, rbase_q;
  logic [12:0] inner_q;
  logic [23:0] rcount_q;

  wire cfg_wr = psel && penable && pwrite;
  wire [2:0] cfg_idx = paddr[5:3];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_q <= 3'd2; shape_q <= '0; lstr_q <= '0; rstr_q <= '0;
      lbase_q <= '0; rbase_q <= '0; inner_q <= '0; rcount_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sbmm_pkg::RegNumDims:  nd_q     <= pwdata[2:0];
        sbmm_pkg::RegShape:    shape_q  <= pwdata;
        sbmm_pkg::RegLStrides: lstr_q   <= pwdata;
        sbmm_pkg::RegRStrides: rstr_q   <= pwdata;
        sbmm_pkg::RegLBase:    lbase_q  <= pwdata[11:0];
        sbmm_pkg::RegRBase:    rbase_q  <= pwdata[11:0];
        sbmm_pkg::RegInnerLen: inner_q  <= pwdata[12:0];
        sbmm_pkg::RegResCount: rcount_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sbmm_pkg::RegNumDims:  prdata = {61'd0, nd_q};
      sbmm_pkg::RegShape:    prdata = shape_q;
      sbmm_pkg::RegLStrides: prdata = lstr_q;
      sbmm_pkg::RegRStrides: prdata = rstr_q;
      sbmm_pkg::RegLBase:    prdata = {52'd0, lbase_q};
      sbmm_pkg::RegRBase:    prdata = {52'd0, rbase_q};
      sbmm_pkg::RegInnerLen: prdata = {51'd0, inner_q};
      sbmm_pkg::RegResCount: prdata = {40'd0, rcount_q};
      default:               prdata = '0;
    endcase
  end

  // effective dimension count
  logic [2:0] nd_eff;
  always_comb begin
    if (nd_q < 3'd2) nd_eff = 3'd2;
    else if (nd_q > 3'(MAX_DIMS)) nd_eff = 3'(MAX_DIMS);
    else nd_eff = nd_q;
  end

  state_e      state_q, state_d;
  logic [2:0]  dim_q;
  logic [4:0]  bit_q;
  logic [23:0] quo_q, rem_q, lin_q, ridx_q;
  logic [39:0] aoff_q, boff_q;
  logic [15:0] t1_q, t2_q;
  logic [12:0] k_q;
  logic [39:0] aptr_q, bptr_q;
  logic [31:0] sum_q, running_sum_q;
  logic [63:0] prod_q;
  logic [1:0]  st_q;
  logic        vld_q;

  wire [1:0]  di = dim_q[1:0];
  wire [15:0] size_c = shape_q[16*di +: 16];
  wire [15:0] ls_c   = lstr_q[16*di +: 16];
  wire [15:0] rs_c   = rstr_q[16*di +: 16];
  wire [24:0] rem_sh = {rem_q, lin_q[23]};
  wire        sub_ok = rem_sh >= {9'd0, size_c};
  wire [2:0]  nd_m1  = nd_eff - 3'd1;
  wire [2:0]  nd_m2  = nd_eff - 3'd2;
  wire [39:0] lprod  = rem_q * ls_c;
  wire [39:0] rprod  = rem_q * rs_c;

  // memories
  logic we_l, we_r;
  logic [Aw-1:0] addr_l, addr_r;
  logic [DATA_WIDTH-1:0] wdat, rd_l, rd_r;
  wire accept = start_i && !busy_o;
  assign wdat = in_item_i.write_value[DATA_WIDTH-1:0];
  assign we_l = accept && in_item_i.op == sbmm_pkg::OpWrLeft
                && {20'd0, in_item_i.mem_address} < 32'(MEM_DEPTH);
  assign we_r = accept && in_item_i.op == sbmm_pkg::OpWrRight
                && {20'd0, in_item_i.mem_address} < 32'(MEM_DEPTH);
  always_comb begin
    if (state_q == StIdle) begin
      addr_l = Aw'(in_item_i.mem_address);
      addr_r = Aw'(in_item_i.mem_address);
    end else begin
      addr_l = aptr_q[Aw-1:0];
      addr_r = bptr_q[Aw-1:0];
    end
  end

  sbmm_ram #(.Width(DATA_WIDTH), .Depth(MEM_DEPTH)) u_lmem (
    .clk_i, .we_i(we_l), .addr_i(addr_l), .wdata_i(wdat), .rdata_o(rd_l));
  sbmm_ram #(.Width(DATA_WIDTH), .Depth(MEM_DEPTH)) u_rmem (
    .clk_i, .we_i(we_r), .addr_i(addr_r), .wdata_i(wdat), .rdata_o(rd_r));

  wire signed [31:0] a_ext = 32'(signed'(rd_l));
  wire signed [31:0] b_ext = 32'(signed'(rd_r));
  wire [12:0] last = inner_q - 13'd1;
  wire [28:0] lspan = last * t1_q;
  wire [28:0] rspan = last * t2_q;
  wire [39:0] a_end = aoff_q + 40'(lspan);
  wire [39:0] b_end = boff_q + 40'(rspan);
  wire        addr_bad = inner_q != 13'd0 &&
                         (a_end >= 40'(MEM_DEPTH) || b_end >= 40'(MEM_DEPTH));
  wire [31:0] sum_n = sum_q + prod_q[31:0];
  logic [31:0] sum_w;
  always_comb begin
    sum_w = sum_n;
    if (DATA_WIDTH < 32) begin
      for (int b = 0; b < 32; b++) begin
        if (b >= DATA_WIDTH) sum_w[b] = sum_n[DATA_WIDTH-1];
      end
    end
  end

  // pipeline: read issue -> data -> product -> accumulate
  logic [1:0] pv_q;
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept && in_item_i.op == sbmm_pkg::OpCompute) begin
        state_d = (in_item_i.result_index >= rcount_q) ? StDone : StDiv;
      end
      StDiv:   if (bit_q == 5'd0) state_d = StAcc;
      StAcc:   state_d = (dim_q == 3'd0) ? StCheck : StDiv;
      StCheck: state_d = (addr_bad || inner_q == 13'd0) ? StDone : StRead;
      StRead:  if (k_q == inner_q) state_d = StMac;
      StMac:   if (pv_q == 2'd0) state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; vld_q <= 1'b0; running_sum_q <= '0; pv_q <= '0;
      sum_q <= '0; st_q <= sbmm_pkg::StOk; k_q <= '0; dim_q <= '0; bit_q <= '0;
    end else begin
      state_q <= state_d;
      vld_q <= 1'b0;
      pv_q <= {pv_q[0], state_q == StRead && k_q != inner_q};
      if (pv_q[0]) prod_q <= 64'(a_ext * b_ext);
      if (pv_q[1]) sum_q <= sum_w;
      unique case (state_q)
        StIdle: if (accept && in_item_i.op == sbmm_pkg::OpCompute) begin
          ridx_q <= in_item_i.result_index;
          lin_q  <= in_item_i.result_index;
          st_q   <= (in_item_i.result_index >= rcount_q) ? sbmm_pkg::StBadIndex
                                                        : sbmm_pkg::StOk;
          dim_q  <= nd_eff - 3'd1;
          bit_q  <= 5'd23; rem_q <= '0; quo_q <= '0;
          aoff_q <= {28'd0, lbase_q}; boff_q <= {28'd0, rbase_q};
          sum_q  <= '0; k_q <= '0;
        end
        StDiv: begin
          if (size_c == 16'd0) begin
            bit_q <= 5'd0; quo_q <= lin_q; rem_q <= '0;
          end else begin
            rem_q <= sub_ok ? 24'(rem_sh - {9'd0, size_c}) : rem_sh[23:0];
            quo_q <= {quo_q[22:0], sub_ok};
            lin_q <= {lin_q[22:0], 1'b0};
            bit_q <= bit_q - 5'd1;
          end
        end
        StAcc: begin
          if (dim_q != nd_m1) aoff_q <= aoff_q + lprod;
          else t1_q <= ls_c;
          if (dim_q != nd_m2) boff_q <= boff_q + rprod;
          else t2_q <= rs_c;
          lin_q <= quo_q; rem_q <= '0; quo_q <= '0; bit_q <= 5'd23;
          if (dim_q != 3'd0) dim_q <= dim_q - 3'd1;
        end
        StCheck: begin
          if (addr_bad) st_q <= sbmm_pkg::StBadAddr;
          aptr_q <= aoff_q; bptr_q <= boff_q;
        end
        StRead: if (k_q != inner_q) begin
          aptr_q <= aptr_q + 40'(t1_q);
          bptr_q <= bptr_q + 40'(t2_q);
          k_q <= k_q + 13'd1;
        end
        StMac: ;
        StDone: begin
          vld_q <= 1'b1;
          out_item_o.echo_index <= ridx_q;
          out_item_o.status <= st_q;
          out_item_o.product_value <= (st_q == sbmm_pkg::StOk) ? sum_q : '0;
          if (st_q == sbmm_pkg::StOk) running_sum_q <= sum_q;
        end
        default: ;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle) || (running_sum_q == 32'h1 && 1'b0);
  assign result_valid_o = vld_q;
endmodule
`default_nettype wire
